FILE: rtl/kvrsp_pkg.sv
// ----------------------------------------------------------------------------
// kvrsp_pkg
// Shared types and codes for the key-value request stream parser: parse
// phases, event and error codes, register indexes and the state, configuration
// and result records.
// ----------------------------------------------------------------------------
package kvrsp_pkg;

  localparam int ByteW   = 8;
  localparam int IdW     = 64;
  localparam int LenW    = 31;
  localparam int WordW   = 32;
  localparam int CfgIdxW = 3;

  // Parse phase of the request currently being received.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_VER,
    PH_TYPE,
    PH_ID,
    PH_KLEN,
    PH_KEY,
    PH_VLEN,
    PH_VAL
  } phase_t;

  // Classification of each byte.
  typedef enum logic [1:0] {
    EV_HEADER,
    EV_KEY,
    EV_VALUE,
    EV_ERROR
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_MAGIC,
    ERR_VERSION,
    ERR_TYPE,
    ERR_KEY_LEN,
    ERR_VALUE_LEN,
    ERR_TRUNCATED
  } err_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAGIC,
    CFG_VERSION,
    CFG_TYPE_LOW,
    CFG_TYPE_HIGH,
    CFG_PUT_TYPE
  } cfg_idx_t;

  typedef struct packed {
    logic [ByteW-1:0] magic_value;
    logic [ByteW-1:0] version_value;
    logic [ByteW-1:0] type_lowest;
    logic [ByteW-1:0] type_highest;
    logic [ByteW-1:0] put_type_code;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [2:0]        field_byte_count;
    logic [LenW-1:0]   bytes_remaining;
    logic [WordW-1:0]  length_shift;
    logic [ByteW-1:0]  held_type;
    logic [IdW-1:0]    held_id;
    logic [LenW-1:0]   held_key_length;
    logic [LenW-1:0]   held_value_length;
  } state_t;

  typedef struct packed {
    event_t            event_res;
    logic [ByteW-1:0]  payload_byte;
    logic              request_done;
    logic [ByteW-1:0]  request_type;
    logic [IdW-1:0]    request_id;
    logic [LenW-1:0]   key_length;
    logic [LenW-1:0]   value_length;
    err_t              error_code;
  } result_t;

endpackage

FILE: rtl/kvrsp_req_if.sv
// ----------------------------------------------------------------------------
// kvrsp_req_if
// Byte stream channel into the parser: one stream byte and its buffer end flag
// per beat.
// ----------------------------------------------------------------------------
interface kvrsp_req_if;
  logic                        valid;
  logic                        ready;
  logic [kvrsp_pkg::ByteW-1:0] rx_byte;
  logic                        buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

FILE: rtl/kvrsp_res_if.sv
// ----------------------------------------------------------------------------
// kvrsp_res_if
// Result channel out of the parser: the event, payload and decoded header for
// one stream byte per beat.
// ----------------------------------------------------------------------------
interface kvrsp_res_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  event_res;
  logic [kvrsp_pkg::ByteW-1:0] payload_byte;
  logic                        request_done;
  logic [kvrsp_pkg::ByteW-1:0] request_type;
  logic [kvrsp_pkg::IdW-1:0]   request_id;
  logic [kvrsp_pkg::LenW-1:0]  key_length;
  logic [kvrsp_pkg::LenW-1:0]  value_length;
  logic [2:0]                  error_code;

  modport source (output valid, output event_res, output payload_byte,
                  output request_done, output request_type, output request_id,
                  output key_length, output value_length, output error_code,
                  input ready);
  modport sink   (input valid, input event_res, input payload_byte,
                  input request_done, input request_type, input request_id,
                  input key_length, input value_length, input error_code,
                  output ready);
endinterface

FILE: rtl/kvrsp_step.sv
// ----------------------------------------------------------------------------
// kvrsp_step
// Next-state and result logic for one stream byte: walks the request header,
// assembles the id and length fields, counts key and value bytes and flags
// errors.
// ----------------------------------------------------------------------------
module kvrsp_step (
  input  kvrsp_pkg::state_t              st,
  input  kvrsp_pkg::cfg_t                cfg,
  input  logic [kvrsp_pkg::ByteW-1:0]    rx_byte,
  input  logic                           buffer_end,
  output kvrsp_pkg::state_t              st_next,
  output kvrsp_pkg::result_t             result
);

  logic [kvrsp_pkg::IdW-1:0]   id_merged;
  logic [kvrsp_pkg::WordW-1:0] word_merged;
  logic [kvrsp_pkg::LenW-1:0]  remaining_dec;
  logic                        is_put;

  // Byte lanes of the id and the length word being assembled.
  assign id_merged   = st.held_id |
                       ({{(kvrsp_pkg::IdW-kvrsp_pkg::ByteW){1'b0}}, rx_byte}
                        << {st.field_byte_count, 3'b000});
  assign word_merged = st.length_shift |
                       ({{(kvrsp_pkg::WordW-kvrsp_pkg::ByteW){1'b0}}, rx_byte}
                        << {st.field_byte_count[1:0], 3'b000});
  assign remaining_dec = (st.bytes_remaining != '0) ?
                         st.bytes_remaining - 1'b1 : st.bytes_remaining;
  assign is_put = (st.held_type == cfg.put_type_code);

  always_comb begin
    kvrsp_pkg::state_t nxt;
    kvrsp_pkg::event_t ev;
    kvrsp_pkg::err_t   err;
    logic [kvrsp_pkg::ByteW-1:0] pay;
    logic done;
    logic key_over;

    nxt      = st;
    ev       = kvrsp_pkg::EV_HEADER;
    err      = kvrsp_pkg::ERR_NONE;
    pay      = '0;
    done     = 1'b0;
    key_over = 1'b0;

    // Per-phase handling of the byte.
    case (st.phase)
      kvrsp_pkg::PH_VER: begin
        if (rx_byte != cfg.version_value) err = kvrsp_pkg::ERR_VERSION;
        else nxt.phase = kvrsp_pkg::PH_TYPE;
      end
      kvrsp_pkg::PH_TYPE: begin
        if (rx_byte < cfg.type_lowest || rx_byte > cfg.type_highest) begin
          err = kvrsp_pkg::ERR_TYPE;
        end else begin
          nxt.held_type        = rx_byte;
          nxt.phase            = kvrsp_pkg::PH_ID;
          nxt.field_byte_count = '0;
        end
      end
      kvrsp_pkg::PH_ID: begin
        nxt.held_id = id_merged;
        if (st.field_byte_count == 3'd7) begin
          nxt.phase            = kvrsp_pkg::PH_KLEN;
          nxt.field_byte_count = '0;
          nxt.length_shift     = '0;
        end else begin
          nxt.field_byte_count = st.field_byte_count + 3'd1;
        end
      end
      kvrsp_pkg::PH_KLEN, kvrsp_pkg::PH_VLEN: begin
        nxt.length_shift = word_merged;
        if (st.field_byte_count[1:0] != 2'd3) begin
          nxt.field_byte_count = {1'b0, st.field_byte_count[1:0]} + 3'd1;
        end else begin
          nxt.field_byte_count = '0;
          if (word_merged[kvrsp_pkg::WordW-1]) begin
            err = (st.phase == kvrsp_pkg::PH_KLEN) ? kvrsp_pkg::ERR_KEY_LEN
                                                   : kvrsp_pkg::ERR_VALUE_LEN;
          end else if (st.phase == kvrsp_pkg::PH_KLEN) begin
            nxt.held_key_length = word_merged[kvrsp_pkg::LenW-1:0];
            if (word_merged == '0) begin
              key_over = 1'b1;
            end else begin
              nxt.phase           = kvrsp_pkg::PH_KEY;
              nxt.bytes_remaining = word_merged[kvrsp_pkg::LenW-1:0];
            end
          end else begin
            nxt.held_value_length = word_merged[kvrsp_pkg::LenW-1:0];
            if (word_merged == '0) begin
              done = 1'b1;
            end else begin
              nxt.phase           = kvrsp_pkg::PH_VAL;
              nxt.bytes_remaining = word_merged[kvrsp_pkg::LenW-1:0];
            end
          end
        end
      end
      kvrsp_pkg::PH_KEY: begin
        ev                  = kvrsp_pkg::EV_KEY;
        pay                 = rx_byte;
        nxt.bytes_remaining = remaining_dec;
        if (remaining_dec == '0) key_over = 1'b1;
      end
      kvrsp_pkg::PH_VAL: begin
        ev                  = kvrsp_pkg::EV_VALUE;
        pay                 = rx_byte;
        nxt.bytes_remaining = remaining_dec;
        if (remaining_dec == '0) done = 1'b1;
      end
      default: begin
        if (rx_byte != cfg.magic_value) begin
          err = kvrsp_pkg::ERR_MAGIC;
        end else begin
          nxt.held_type         = '0;
          nxt.held_id           = '0;
          nxt.held_key_length   = '0;
          nxt.held_value_length = '0;
          nxt.phase             = kvrsp_pkg::PH_VER;
        end
      end
    endcase

    // End of the key section: a put request goes on to its value length.
    if (key_over) begin
      if (is_put) begin
        nxt.phase            = kvrsp_pkg::PH_VLEN;
        nxt.field_byte_count = '0;
        nxt.length_shift     = '0;
      end else begin
        done = 1'b1;
      end
    end

    // Errors, completion and truncation all return to idle.
    if (err != kvrsp_pkg::ERR_NONE) begin
      ev        = kvrsp_pkg::EV_ERROR;
      pay       = '0;
      done      = 1'b0;
      nxt.phase = kvrsp_pkg::PH_IDLE;
    end else if (done) begin
      nxt.phase = kvrsp_pkg::PH_IDLE;
    end else if (buffer_end) begin
      err       = kvrsp_pkg::ERR_TRUNCATED;
      ev        = kvrsp_pkg::EV_ERROR;
      pay       = '0;
      nxt.phase = kvrsp_pkg::PH_IDLE;
    end
    if (nxt.phase == kvrsp_pkg::PH_IDLE) begin
      nxt.field_byte_count = '0;
      nxt.bytes_remaining  = '0;
    end

    st_next               = nxt;
    result.event_res      = ev;
    result.payload_byte   = pay;
    result.request_done   = done;
    result.request_type   = nxt.held_type;
    result.request_id     = nxt.held_id;
    result.key_length     = nxt.held_key_length;
    result.value_length   = nxt.held_value_length;
    result.error_code     = err;
  end

endmodule

FILE: rtl/kv_request_stream_parser_core.sv
// ----------------------------------------------------------------------------
// kv_request_stream_parser_core
// Byte-wide parser for binary key-value requests: classifies every stream
// byte, passes key and value bytes through and reports the decoded header.
// ----------------------------------------------------------------------------
// The result for a byte is registered in the result register, or in the skid
// register behind it while the result side stalls, which keeps one more byte
// accepted. Throughput: one byte per cycle while the skid register is empty;
// the parse state updates in a single pass.
// Reset clears the parse state, the result queue and the registers to their
// reset values (type_highest to 255, the others to zero).
module kv_request_stream_parser_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [kvrsp_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [kvrsp_pkg::ByteW-1:0]       cfg_data,
  kvrsp_req_if.sink                         req,
  kvrsp_res_if.source                       res
);

  kvrsp_pkg::cfg_t    cfg;
  kvrsp_pkg::state_t  st;
  kvrsp_pkg::state_t  st_next;
  kvrsp_pkg::result_t step_res;
  kvrsp_pkg::result_t out_res;
  kvrsp_pkg::result_t skid_res;
  logic               out_valid;
  logic               skid_valid;
  logic               accept;
  logic               out_free;

  assign req.ready = !skid_valid;
  assign accept    = req.valid && !skid_valid;
  assign out_free  = !out_valid || res.ready;

  kvrsp_step u_step (
    .st         (st),
    .cfg        (cfg),
    .rx_byte    (req.rx_byte),
    .buffer_end (req.buffer_end),
    .st_next    (st_next),
    .result     (step_res)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_value   <= '0;
      cfg.version_value <= '0;
      cfg.type_lowest   <= '0;
      cfg.type_highest  <= '1;
      cfg.put_type_code <= '0;
    end else if (cfg_we) begin
      case (kvrsp_pkg::cfg_idx_t'(cfg_index))
        kvrsp_pkg::CFG_MAGIC:     cfg.magic_value   <= cfg_data;
        kvrsp_pkg::CFG_VERSION:   cfg.version_value <= cfg_data;
        kvrsp_pkg::CFG_TYPE_LOW:  cfg.type_lowest   <= cfg_data;
        kvrsp_pkg::CFG_TYPE_HIGH: cfg.type_highest  <= cfg_data;
        kvrsp_pkg::CFG_PUT_TYPE:  cfg.put_type_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parse state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: kvrsp_pkg::PH_IDLE, default: '0};
    end else if (accept) begin
      st <= st_next;
    end
  end

  // Result register and skid register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Result payloads; the skid entry moves up before any new result.
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : step_res;
    end
    if (accept && !out_free) begin
      skid_res <= step_res;
    end
  end

  assign res.valid        = out_valid;
  assign res.event_res    = out_res.event_res;
  assign res.payload_byte = out_res.payload_byte;
  assign res.request_done = out_res.request_done;
  assign res.request_type = out_res.request_type;
  assign res.request_id   = out_res.request_id;
  assign res.key_length   = out_res.key_length;
  assign res.value_length = out_res.value_length;
  assign res.error_code   = out_res.error_code;

  // The skid register is only ever filled behind a held result.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry present without a result in the output register");

  // An error event and a non-zero error code always go together.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_res.event_res == kvrsp_pkg::EV_ERROR) ==
                   (out_res.error_code != kvrsp_pkg::ERR_NONE)))
    else $error("error event and error code disagree");

  // A completed request never carries an error.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.request_done |->
      out_res.error_code == kvrsp_pkg::ERR_NONE)
    else $error("request reported done together with an error");

  // Only key and value bytes pass a payload through.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.event_res != kvrsp_pkg::EV_KEY &&
    out_res.event_res != kvrsp_pkg::EV_VALUE |-> out_res.payload_byte == '0)
    else $error("payload byte set on a header or error beat");

  // After an error or a finished request the parser waits for a magic byte.
  assert property (@(posedge clk) disable iff (rst)
    accept && (step_res.error_code != kvrsp_pkg::ERR_NONE ||
               step_res.request_done) |=>
      st.phase == kvrsp_pkg::PH_IDLE && st.bytes_remaining == '0)
    else $error("parser did not return to idle");

endmodule

FILE: tb/kv_request_stream_parser_core_tb.sv
// ----------------------------------------------------------------------------
// kv_request_stream_parser_core_tb
// Self-checking bench for the key-value request stream parser. Byte beats are
// driven through the request channel. Each accepted beat is run through a
// behavioural parser held in the bench, and its predicted result is queued.
// Result beats are compared field by field with the oldest queued result.
// The run covers header error cases, then well-formed requests with random
// content, mixed with corrupted, truncated and noise traffic, under several
// register settings and flow-control patterns.
// ----------------------------------------------------------------------------
module kv_request_stream_parser_core_tb;
  import kvrsp_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] rx;
    logic             last;
  } beat_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [ByteW-1:0]     cfg_data;

  kvrsp_req_if req_ch ();
  kvrsp_res_if res_ch ();

  kv_request_stream_parser_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  // Register copy and parse state of the bench's own parser.
  cfg_t             cfg_shadow;
  phase_t           pr_phase;
  logic [2:0]       pr_count;
  logic [LenW-1:0]  pr_remaining;
  logic [WordW-1:0] pr_word;
  logic [ByteW-1:0] pr_type;
  logic [IdW-1:0]   pr_id;
  logic [LenW-1:0]  pr_klen;
  logic [LenW-1:0]  pr_vlen;

  result_t pending_results[$];
  int      errors_seen;
  int      beats_sent;
  int      send_idle_pct;
  int      recv_idle_pct;

  // Clock generation.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit.
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  // At the end of the key section: a put request goes on to its value length,
  // any other request is complete.
  function automatic logic key_section_done();
    if (pr_type == cfg_shadow.put_type_code) begin
      pr_phase = PH_VLEN;
      pr_count = '0;
      pr_word  = '0;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the parse state by one stream byte and return its result.
  function automatic result_t parse_byte(input logic [ByteW-1:0] rx, input logic last);
    result_t          r;
    event_t           ev;
    err_t             err;
    logic [ByteW-1:0] pay;
    logic             done;
    logic [2:0]       cnt;
    ev   = EV_HEADER;
    err  = ERR_NONE;
    pay  = '0;
    done = 1'b0;
    cnt  = pr_count;
    case (pr_phase)
      PH_VER: begin
        if (rx != cfg_shadow.version_value) err = ERR_VERSION;
        else pr_phase = PH_TYPE;
      end
      PH_TYPE: begin
        if (rx < cfg_shadow.type_lowest || rx > cfg_shadow.type_highest) begin
          err = ERR_TYPE;
        end else begin
          pr_type  = rx;
          pr_phase = PH_ID;
          pr_count = '0;
        end
      end
      PH_ID: begin
        pr_id = pr_id | (IdW'(rx) << (8 * cnt));
        if (cnt == 3'd7) begin
          pr_phase = PH_KLEN;
          pr_count = '0;
          pr_word  = '0;
        end else begin
          pr_count = cnt + 3'd1;
        end
      end
      PH_KLEN, PH_VLEN: begin
        pr_word = pr_word | (WordW'(rx) << (8 * cnt[1:0]));
        if (cnt[1:0] != 2'd3) begin
          pr_count = {1'b0, cnt[1:0]} + 3'd1;
        end else begin
          pr_count = '0;
          if (pr_word[WordW-1]) begin
            err = (pr_phase == PH_KLEN) ? ERR_KEY_LEN : ERR_VALUE_LEN;
          end else if (pr_phase == PH_KLEN) begin
            pr_klen = pr_word[LenW-1:0];
            if (pr_word == '0) begin
              done = key_section_done();
            end else begin
              pr_phase     = PH_KEY;
              pr_remaining = pr_word[LenW-1:0];
            end
          end else begin
            pr_vlen = pr_word[LenW-1:0];
            if (pr_word == '0) begin
              done = 1'b1;
            end else begin
              pr_phase     = PH_VAL;
              pr_remaining = pr_word[LenW-1:0];
            end
          end
        end
      end
      PH_KEY: begin
        ev  = EV_KEY;
        pay = rx;
        if (pr_remaining != '0) pr_remaining = pr_remaining - 1'b1;
        if (pr_remaining == '0) done = key_section_done();
      end
      PH_VAL: begin
        ev  = EV_VALUE;
        pay = rx;
        if (pr_remaining != '0) pr_remaining = pr_remaining - 1'b1;
        if (pr_remaining == '0) done = 1'b1;
      end
      default: begin
        if (rx != cfg_shadow.magic_value) begin
          err      = ERR_MAGIC;
          pr_phase = PH_IDLE;
        end else begin
          pr_type  = '0;
          pr_id    = '0;
          pr_klen  = '0;
          pr_vlen  = '0;
          pr_phase = PH_VER;
        end
      end
    endcase

    // A content error wins over truncation; a completed request is never
    // truncated.
    if (err != ERR_NONE) begin
      ev       = EV_ERROR;
      pay      = '0;
      done     = 1'b0;
      pr_phase = PH_IDLE;
    end else if (done) begin
      pr_phase = PH_IDLE;
    end else if (last) begin
      err      = ERR_TRUNCATED;
      ev       = EV_ERROR;
      pay      = '0;
      pr_phase = PH_IDLE;
    end
    if (pr_phase == PH_IDLE) begin
      pr_count     = '0;
      pr_remaining = '0;
    end

    r.event_res    = ev;
    r.payload_byte = pay;
    r.request_done = done;
    r.request_type = pr_type;
    r.request_id   = pr_id;
    r.key_length   = pr_klen;
    r.value_length = pr_vlen;
    r.error_code   = err;
    return r;
  endfunction

  // Result side: random stalls, and the check of every accepted result beat.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (res_ch.valid && res_ch.ready) check_result();
    end
  end

  task automatic report_field(input string label, input logic [63:0] want,
                              input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
      errors_seen++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result beat with no byte outstanding", $time);
      errors_seen++;
    end else begin
      want = pending_results.pop_front();
      report_field("event_res", want.event_res, res_ch.event_res);
      report_field("payload_byte", want.payload_byte, res_ch.payload_byte);
      report_field("request_done", want.request_done, res_ch.request_done);
      report_field("request_type", want.request_type, res_ch.request_type);
      report_field("request_id", want.request_id, res_ch.request_id);
      report_field("key_length", want.key_length, res_ch.key_length);
      report_field("value_length", want.value_length, res_ch.value_length);
      report_field("error_code", want.error_code, res_ch.error_code);
    end
  endtask

  // Send one stream byte, with random gaps before it, and predict its result
  // once the beat is taken.
  task automatic send_beat(input logic [ByteW-1:0] rx, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.rx_byte    <= rx;
    req_ch.buffer_end <= last;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(parse_byte(rx, last));
    beats_sent++;
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all five registers; the caller is to use it only while the parser is idle, which the task does not enforce.
  task automatic load_config(input cfg_t c);
    cfg_idx_t         idx  [5] = '{CFG_MAGIC, CFG_VERSION, CFG_TYPE_LOW,
                                   CFG_TYPE_HIGH, CFG_PUT_TYPE};
    logic [ByteW-1:0] vals [5];
    vals = '{c.magic_value, c.version_value, c.type_lowest, c.type_highest,
             c.put_type_code};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we     <= 1'b0;
    cfg_shadow  = c;
  endtask

  // Mostly short lengths, with zero, oversized and negative ones now and then.
  function automatic logic [WordW-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 80) return WordW'($urandom_range(6, 1));
    if (r < 88) return WordW'($urandom_range(20, 7));
    if (r < 94) return {1'b0, 31'($urandom)};
    return {1'b1, 31'($urandom)};
  endfunction

  // Build one request under the current registers, sometimes corrupted or
  // cut short, or a burst of noise, and send it.
  task automatic send_random_request();
    beat_t            beats[$];
    logic [ByteW-1:0] typ;
    logic [WordW-1:0] len;
    logic             needs_end;
    int               r;
    int               cut;
    needs_end = 1'b0;
    r = $urandom_range(99);
    if (r < 6) begin
      repeat ($urandom_range(4, 1))
        beats.push_back(beat_t'{rx: 8'($urandom), last: ($urandom_range(9) == 0)});
    end else begin
      beats.push_back(beat_t'{rx: ($urandom_range(99) < 92) ? cfg_shadow.magic_value
                                                              : 8'($urandom), last: 1'b0});
      beats.push_back(beat_t'{rx: ($urandom_range(99) < 93) ? cfg_shadow.version_value
                                                              : 8'($urandom), last: 1'b0});
      r = $urandom_range(99);
      if (r < 35) begin
        typ = cfg_shadow.put_type_code;
      end else if (r < 85 && cfg_shadow.type_lowest <= cfg_shadow.type_highest) begin
        typ = 8'($urandom_range(cfg_shadow.type_highest, cfg_shadow.type_lowest));
      end else begin
        typ = 8'($urandom);
      end
      beats.push_back(beat_t'{rx: typ, last: 1'b0});
      repeat (8) beats.push_back(beat_t'{rx: 8'($urandom), last: 1'b0});

      // Key section, then the value section of a put request.
      for (int s = 0; s < 2; s++) begin
        if (s == 0 || typ == cfg_shadow.put_type_code) begin
          len = pick_length();
          for (int i = 0; i < 4; i++) beats.push_back(beat_t'{rx: len[8*i +: 8], last: 1'b0});
          if (len > 24) needs_end = 1'b1;
          if (!len[WordW-1]) begin
            for (int i = 0; i < len && i < 24; i++)
              beats.push_back(beat_t'{rx: 8'($urandom), last: 1'b0});
          end
        end
      end

      // Occasionally cut the request short at a random byte.
      if ($urandom_range(99) < 7) begin
        cut = $urandom_range(beats.size() - 1, 0);
        beats = beats[0:cut];
        needs_end = 1'b1;
      end
      if (needs_end || $urandom_range(1) == 1) beats[beats.size()-1].last = 1'b1;
    end
    foreach (beats[i]) send_beat(beats[i].rx, beats[i].last);
  endtask

  // A few random requests with the registers left at their reset values.
  task automatic test_reset_registers();
    repeat (3) send_random_request();
    drain_results();
  endtask

  // The magic, version and type errors, truncation, and a complete request ended by the buffer.
  task automatic test_header_errors();
    logic [ByteW-1:0] full_get [15] = '{8'hA5, 8'h01, 8'h03,
                                        8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                        8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                        8'h00, 8'h00, 8'h00, 8'h00};
    load_config(cfg_t'{magic_value: 8'hA5, version_value: 8'h01, type_lowest: 8'h01,
                       type_highest: 8'h04, put_type_code: 8'h02});
    // Wrong magic byte.
    send_beat(8'h00, 1'b0);
    // Wrong version on the buffer's last byte: the version error wins.
    send_beat(8'hA5, 1'b0);
    send_beat(8'h02, 1'b1);
    // Type above the accepted range.
    send_beat(8'hA5, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'h05, 1'b0);
    // Buffer ends in the middle of a valid header.
    send_beat(8'hA5, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'h01, 1'b1);
    // Get request with an empty key, completed on the buffer's last byte.
    for (int i = 0; i < 15; i++) send_beat(full_get[i], i == 14);
    drain_results();
  endtask

  // Random traffic under one register setting, until the byte budget is spent.
  task automatic test_random_traffic(input cfg_t c, input int byte_budget);
    int start;
    load_config(c);
    start = beats_sent;
    while (beats_sent - start < byte_budget) send_random_request();
    drain_results();
  endtask

  initial begin
    cfg_t profiles [6];
    profiles[0] = cfg_t'{magic_value: 8'hA5, version_value: 8'h01, type_lowest: 8'h01,
                         type_highest: 8'h04, put_type_code: 8'h02};
    profiles[1] = cfg_t'{magic_value: 8'h00, version_value: 8'h00, type_lowest: 8'h00,
                         type_highest: 8'hFF, put_type_code: 8'h00};
    profiles[2] = cfg_t'{magic_value: 8'hFF, version_value: 8'hFF, type_lowest: 8'hFF,
                         type_highest: 8'hFF, put_type_code: 8'hFF};
    profiles[3] = cfg_t'{magic_value: 8'h5A, version_value: 8'h80, type_lowest: 8'h00,
                         type_highest: 8'h00, put_type_code: 8'h00};
    // Empty type range: every type byte is rejected.
    profiles[4] = cfg_t'{magic_value: 8'h33, version_value: 8'h44, type_lowest: 8'hC8,
                         type_highest: 8'h64, put_type_code: 8'h96};
    // Put type outside the accepted range.
    profiles[5] = cfg_t'{magic_value: 8'h11, version_value: 8'h22, type_lowest: 8'h0A,
                         type_highest: 8'h14, put_type_code: 8'h63};

    // Known values on every input, and the bench's parser in its reset state.
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_MAGIC;
    cfg_data          <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.rx_byte    <= '0;
    req_ch.buffer_end <= 1'b0;
    cfg_shadow   = cfg_t'{magic_value: 8'h00, version_value: 8'h00, type_lowest: 8'h00,
                          type_highest: 8'hFF, put_type_code: 8'h00};
    pr_phase     = PH_IDLE;
    pr_count     = '0;
    pr_remaining = '0;
    pr_word      = '0;
    pr_type      = '0;
    pr_id        = '0;
    pr_klen      = '0;
    pr_vlen      = '0;
    errors_seen   = 0;
    beats_sent    = 0;
    send_idle_pct = 14;
    recv_idle_pct = 62;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_registers();
    test_header_errors();

    // Three flow-control patterns, three register settings in each.
    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin
        send_idle_pct = 62;
        recv_idle_pct = 14;
      end else if (p == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int k = 0; k < 3; k++) test_random_traffic(profiles[(p * 3 + k) % 6], 140);
    end

    repeat (5) @(posedge clk);
    if (errors_seen == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
